>>> hw/rtl/prq_pkg.sv
package prq_pkg;

   // request codes
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_YIELD  = 2'd1;
   localparam logic [1:0] REQ_EXIT   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DISPATCHED = 2'd0;
   localparam logic [1:0] STATUS_QUEUED     = 2'd1;
   localparam logic [1:0] STATUS_EMPTY      = 2'd2;
   localparam logic [1:0] STATUS_FULL       = 2'd3;

   localparam int PRIO_W   = 8;
   localparam int STAMP_W  = 32;
   localparam int WORKER_W = 7;

   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_ID_WIDTH    = 16;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_WORKERS = '0;
   localparam logic [WORKER_W-1:0] MAX_WORKERS_RESET = 7'd1;

   typedef struct packed {
      logic               better;
      logic [STAMP_W-1:0] age;
   } cmp_result_type;

endpackage

>>> hw/rtl/prq_cmp.sv
module prq_cmp #(
   parameter int IDX_W = 6
) (
   input  logic [prq_pkg::PRIO_W-1:0]  cand_prio,
   input  logic [prq_pkg::STAMP_W-1:0] cand_stamp,
   input  logic [IDX_W-1:0]            cand_idx,
   input  logic [prq_pkg::STAMP_W-1:0] now_stamp,
   input  logic                        ref_any,
   input  logic [prq_pkg::PRIO_W-1:0]  ref_prio,
   input  logic [prq_pkg::STAMP_W-1:0] ref_age,
   input  logic [IDX_W-1:0]            ref_idx,
   output prq_pkg::cmp_result_type     result
);

   logic [prq_pkg::STAMP_W-1:0] age;

   // age wraps with the arrival counter
   assign age = now_stamp - cand_stamp;

   always_comb begin
      result.age    = age;
      result.better = !ref_any ||
                      (cand_prio < ref_prio) ||
                      ((cand_prio == ref_prio) &&
                       ((age > ref_age) || ((age == ref_age) && (cand_idx < ref_idx))));
   end

endmodule

>>> hw/rtl/prq_mem.sv
module prq_mem #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 57,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/priority_ready_queue_dispatcher_core.sv
// Thread ready queue with priority dispatch and oldest-first tie break.
// Requests come in on start/req_*: a request is taken at a clock edge where
// start is high and busy is low. Create and yield insert a thread, exit
// releases a worker; dispatch removes the entry with the lowest priority
// number, the oldest one among equals.
// Every request gives exactly one result word on rsp_*, marked by rsp_valid
// for a single cycle. The receiver has no way to hold it off, so it must take
// the word in that cycle.
// Each request reads every queue slot through the one read port of the entry
// memory and runs them through a single compare unit, in the states SCAN,
// DRAIN, DECIDE and DEL; the result strobe rises as busy falls, so a new
// request is taken only after the last one has given its result.
// After reset the block sweeps the entry memory to empty, one slot a cycle,
// and holds busy high until the sweep is done. The max_workers register
// on the APB-style port can be written at any time the block is not busy
// with a request; it resets to one.
module priority_ready_queue_dispatcher_core #(
   parameter int QUEUE_DEPTH = prq_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_WIDTH    = prq_pkg::DEF_ID_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [ID_WIDTH-1:0]               req_thread_id,
   input  logic [prq_pkg::PRIO_W-1:0]        req_priority_req,
   // result channel
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [ID_WIDTH-1:0]               rsp_dispatch_id,
   output logic [prq_pkg::PRIO_W-1:0]        rsp_dispatch_priority,
   output logic [prq_pkg::WORKER_W-1:0]      rsp_running_workers,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [prq_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [prq_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [prq_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PW      = prq_pkg::PRIO_W;
   localparam int SW      = prq_pkg::STAMP_W;
   localparam int WW      = prq_pkg::WORKER_W;
   localparam int ENTRY_W = 1 + PW + SW + ID_WIDTH;
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_DEL    = 3'd5;

   // control
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [SW-1:0] counter_ff, counter_in;
   logic [WW-1:0] workers_ff, workers_in;
   logic [WW-1:0] max_workers_ff, max_workers_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          best_any_ff, best_any_in;
   logic          free_found_ff, free_found_in;
   logic          do_del_ff, do_del_in;

   // request and scan payload
   logic [1:0]          op_ff, op_in;
   logic [ID_WIDTH-1:0] tid_ff, tid_in;
   logic [PW-1:0]       prio_ff, prio_in;
   logic [SW-1:0]       now_ff, now_in;
   logic [AW-1:0]       free_idx_ff, free_idx_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   logic [PW-1:0]       best_prio_ff, best_prio_in;
   logic [SW-1:0]       best_age_ff, best_age_in;
   logic [ID_WIDTH-1:0] best_tid_ff, best_tid_in;

   // result word
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0] rsp_id_ff, rsp_id_in;
   logic [PW-1:0]       rsp_prio_ff, rsp_prio_in;
   logic [WW-1:0]       rsp_workers_ff, rsp_workers_in;

   // memory and compare unit
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [ENTRY_W-1:0]  mem_wr_data;
   logic                mem_rd_en;
   logic [ENTRY_W-1:0]  mem_rd_data;

   logic                rd_valid_bit;
   logic [PW-1:0]       rd_prio;
   logic [SW-1:0]       rd_stamp;
   logic [ID_WIDTH-1:0] rd_tid;

   logic [PW-1:0]       cmp_prio;
   logic [SW-1:0]       cmp_stamp;
   logic [AW-1:0]       cmp_idx;
   prq_pkg::cmp_result_type cmp_res;

   logic csr_wr;
   logic csr_hit;
   logic is_ins;
   logic want_dispatch;

   assign rd_valid_bit = mem_rd_data[ENTRY_W-1];
   assign rd_prio      = mem_rd_data[ID_WIDTH+SW +: PW];
   assign rd_stamp     = mem_rd_data[ID_WIDTH +: SW];
   assign rd_tid       = mem_rd_data[ID_WIDTH-1:0];

   prq_mem #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (ENTRY_W),
      .ADDR_W (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (mem_rd_data)
   );

   // during the scan the candidate is the slot just read; at decide it is
   // the new thread, which sits at the free slot with the previous stamp
   always_comb begin
      if (state_ff == ST_DECIDE) begin
         cmp_prio  = prio_ff;
         cmp_stamp = counter_ff;
         cmp_idx   = free_idx_ff;
      end else begin
         cmp_prio  = rd_prio;
         cmp_stamp = rd_stamp;
         cmp_idx   = rd_idx_ff;
      end
   end

   prq_cmp #(
      .IDX_W (AW)
   ) u_cmp (
      .cand_prio  (cmp_prio),
      .cand_stamp (cmp_stamp),
      .cand_idx   (cmp_idx),
      .now_stamp  (now_ff),
      .ref_any    (best_any_ff),
      .ref_prio   (best_prio_ff),
      .ref_age    (best_age_ff),
      .ref_idx    (best_idx_ff),
      .result     (cmp_res)
   );

   assign csr_hit = (paddr[prq_pkg::CSR_ADDR_W-1:2] == prq_pkg::REG_MAX_WORKERS);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign is_ins  = (op_ff == prq_pkg::REQ_CREATE) || (op_ff == prq_pkg::REQ_YIELD);
   assign want_dispatch = (op_ff == prq_pkg::REQ_YIELD) || (workers_ff < max_workers_ff);

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = ptr_ff;
      counter_in     = counter_ff;
      workers_in     = workers_ff;
      max_workers_in = max_workers_ff;
      rsp_valid_in   = 1'b0;
      best_any_in    = best_any_ff;
      free_found_in  = free_found_ff;
      do_del_in      = do_del_ff;
      op_in          = op_ff;
      tid_in         = tid_ff;
      prio_in        = prio_ff;
      now_in         = now_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_prio_in   = best_prio_ff;
      best_age_in    = best_age_ff;
      best_tid_in    = best_tid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_workers_in = rsp_workers_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = ptr_ff;
      mem_wr_data    = '0;
      mem_rd_en      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            if (ptr_ff == LAST_IDX) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in         = req_type;
               tid_in        = req_thread_id;
               prio_in       = req_priority_req;
               best_any_in   = 1'b0;
               free_found_in = 1'b0;
               do_del_in     = 1'b0;
               ptr_in        = '0;
               // ages are taken against the counter as it stands after the insert
               if ((req_type == prq_pkg::REQ_CREATE) || (req_type == prq_pkg::REQ_YIELD)) begin
                  now_in = counter_ff + 1'b1;
               end else begin
                  now_in = counter_ff;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mem_rd_en = 1'b1;
            rd_vld_in = 1'b1;
            if (ptr_ff == LAST_IDX) begin
               ptr_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_id_in   = '0;
            rsp_prio_in = '0;
            do_del_in   = 1'b0;
            mem_wr_addr = free_idx_ff;
            mem_wr_data = {1'b1, prio_ff, counter_ff, tid_ff};
            if (is_ins && !free_found_ff) begin
               rsp_status_in = prq_pkg::STATUS_FULL;
            end else if (is_ins) begin
               counter_in = counter_ff + 1'b1;
               if (want_dispatch) begin
                  rsp_status_in = prq_pkg::STATUS_DISPATCHED;
                  if (op_ff == prq_pkg::REQ_CREATE) begin
                     workers_in = workers_ff + 1'b1;
                  end
                  if (cmp_res.better) begin
                     // new thread runs at once and never lands in the queue
                     rsp_id_in   = tid_ff;
                     rsp_prio_in = prio_ff;
                  end else begin
                     mem_wr_en   = 1'b1;
                     rsp_id_in   = best_tid_ff;
                     rsp_prio_in = best_prio_ff;
                     do_del_in   = 1'b1;
                  end
               end else begin
                  mem_wr_en     = 1'b1;
                  rsp_status_in = prq_pkg::STATUS_QUEUED;
               end
            end else if (op_ff == prq_pkg::REQ_EXIT) begin
               if (workers_ff != '0) begin
                  workers_in = workers_ff - 1'b1;
               end
               if (best_any_ff) begin
                  rsp_status_in = prq_pkg::STATUS_DISPATCHED;
                  rsp_id_in     = best_tid_ff;
                  rsp_prio_in   = best_prio_ff;
                  do_del_in     = 1'b1;
               end else begin
                  rsp_status_in = prq_pkg::STATUS_EMPTY;
               end
            end else begin
               rsp_status_in = prq_pkg::STATUS_QUEUED;
            end
            rsp_workers_in = workers_in;
            state_in       = ST_DEL;
         end
         ST_DEL: begin
            mem_wr_addr  = best_idx_ff;
            mem_wr_data  = '0;
            mem_wr_en    = do_del_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // fold the word read last cycle into the running best and first free slot
      if (rd_vld_ff) begin
         if (rd_valid_bit) begin
            if (cmp_res.better) begin
               best_any_in  = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_prio_in = rd_prio;
               best_age_in  = cmp_res.age;
               best_tid_in  = rd_tid;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (csr_wr && csr_hit) begin
         max_workers_in = pwdata[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ptr_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         counter_ff     <= '0;
         workers_ff     <= '0;
         max_workers_ff <= prq_pkg::MAX_WORKERS_RESET;
         rsp_valid_ff   <= 1'b0;
         best_any_ff    <= 1'b0;
         free_found_ff  <= 1'b0;
         do_del_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         rd_vld_ff      <= rd_vld_in;
         counter_ff     <= counter_in;
         workers_ff     <= workers_in;
         max_workers_ff <= max_workers_in;
         rsp_valid_ff   <= rsp_valid_in;
         best_any_ff    <= best_any_in;
         free_found_ff  <= free_found_in;
         do_del_ff      <= do_del_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      op_ff          <= op_in;
      tid_ff         <= tid_in;
      prio_ff        <= prio_in;
      now_ff         <= now_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_prio_ff   <= best_prio_in;
      best_age_ff    <= best_age_in;
      best_tid_ff    <= best_tid_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_workers_ff <= rsp_workers_in;
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_dispatch_id       = rsp_id_ff;
   assign rsp_dispatch_priority = rsp_prio_ff;
   assign rsp_running_workers   = rsp_workers_ff;
   assign pready                = 1'b1;
   assign prdata                = csr_hit ? prq_pkg::CSR_DATA_W'(max_workers_ff) : '0;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_del_has_best: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DEL) && do_del_ff) |-> best_any_ff)
      else $error("removing a slot that was never chosen");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((counter_ff == $past(counter_ff)) ||
                (counter_ff == ($past(counter_ff) + 32'd1))))
      else $error("arrival counter jumped");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != prq_pkg::STATUS_DISPATCHED)) |->
         ((rsp_id_ff == '0) && (rsp_prio_ff == '0)))
      else $error("dispatch fields set without a dispatch");

endmodule
